FILE: sv/tcgp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcgp_pkg
// Shared types and constants of the two-color gradient pixel block.
// ----------------------------------------------------------------------------
package tcgp_pkg;

   localparam int MAX_DIM_DEFAULT = 4096;

   localparam int NUM_W = 15;   // divider numerator
   localparam int DEN_W = 14;   // divider denominator
   localparam int T_W   = 17;   // gradient position, 16 fraction bits
   localparam int SQ_W  = 34;   // sum of squared axis distances

   localparam logic [T_W-1:0] ONE_FX = 17'h10000;

   typedef enum logic [2:0] {
      KIND_HORIZ    = 3'd0,
      KIND_VERT     = 3'd1,
      KIND_DIAG     = 3'd2,
      KIND_XDIAG    = 3'd3,
      KIND_PIPE     = 3'd4,
      KIND_ELLIPTIC = 3'd5,
      KIND_RECT     = 3'd6,
      KIND_PYRAMID  = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      REG_WIDTH     = 3'd0,
      REG_HEIGHT    = 3'd1,
      REG_START     = 3'd2,
      REG_END       = 3'd3,
      REG_KIND      = 3'd4,
      REG_INTERLACE = 3'd5
   } reg_index_type;

endpackage
`default_nettype wire

FILE: sv/tcgp_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcgp_req_if
// Pixel coordinate channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcgp_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] pixel_col;
   logic [11:0] pixel_row;

   modport source (output valid, output pixel_col, output pixel_row, input ready);
   modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface
`default_nettype wire

FILE: sv/tcgp_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcgp_rsp_if
// Premultiplied ARGB result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcgp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_argb;

   modport source (output valid, output pixel_argb, input ready);
   modport sink   (input valid, input pixel_argb, output ready);
endinterface
`default_nettype wire

FILE: sv/two_color_gradient_pixel.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one pixel per cycle; the pipeline stalls as a whole only while
// a finished rsp beat waits for ready.
// Reset clears the stage valid bits and restores each config register to
// its reset value (1x1 rectangle, opaque black, horizontal, no interlace).
// ----------------------------------------------------------------------------
// two_color_gradient_pixel
// Premultiplied ARGB color of one pixel of a two-color gradient rectangle.
// ----------------------------------------------------------------------------
module two_color_gradient_pixel #(
   parameter int MAX_DIM = tcgp_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   tcgp_req_if.sink         req_bus,
   tcgp_rsp_if.source       rsp_bus,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   localparam int DIM_CAP = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
   localparam logic [12:0] DIM_CAP_V = 13'(DIM_CAP);
   localparam int NW  = tcgp_pkg::NUM_W;
   localparam int DW  = tcgp_pkg::DEN_W;
   localparam int TW  = tcgp_pkg::T_W;
   localparam int SW  = tcgp_pkg::SQ_W;
   // stage map: input 0, divider 1..17, products 18, position 19,
   // root 20..36, final position 37, blend 38, channel 39, alpha 40, out 41
   localparam int LAT      = 42;
   localparam int SQ_STEPS = SW / 2;

   // ---------------- configuration registers ----------------
   logic [12:0]        width_ff, height_ff;
   logic [31:0]        start_ff, end_ff;
   tcgp_pkg::kind_type kind_ff;
   logic               ilace_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd1;
         height_ff <= 13'd1;
         start_ff  <= 32'hFF00_0000;
         end_ff    <= 32'hFF00_0000;
         kind_ff   <= tcgp_pkg::KIND_HORIZ;
         ilace_ff  <= 1'b0;
      end else if (csr_we) begin
         // unlisted indexes drop silently
         case (csr_index)
            tcgp_pkg::REG_WIDTH:     width_ff  <= csr_wdata[12:0];
            tcgp_pkg::REG_HEIGHT:    height_ff <= csr_wdata[12:0];
            tcgp_pkg::REG_START:     start_ff  <= csr_wdata;
            tcgp_pkg::REG_END:       end_ff    <= csr_wdata;
            tcgp_pkg::REG_KIND:      kind_ff   <= tcgp_pkg::kind_type'(csr_wdata[2:0]);
            tcgp_pkg::REG_INTERLACE: ilace_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   // One global advance: every stage moves when the output slot is free or
   // being emptied, so no beat is lost or repeated under back-pressure.
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] odd_ff;
   logic           advance;

   assign advance       = !vld_ff[LAT-1] || rsp_bus.ready;
   assign req_bus.ready = advance;
   assign rsp_bus.valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAT-2:0], req_bus.valid};
      end
   end

   // row parity rides along for the interlace step
   always_ff @(posedge clock) begin
      if (advance) begin
         odd_ff <= {odd_ff[LAT-2:0], req_bus.pixel_row[0]};
      end
   end

   // ---------------- stage 0: capture coordinate ----------------
   logic [11:0] x_ff, y_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff <= req_bus.pixel_col;
         y_ff <= req_bus.pixel_row;
      end
   end

   // ---------------- divider operands ----------------
   // Clamp oversized dimensions, then pick numerator and denominator for the
   // two dividers: A carries the x term (or the diagonal), B the y term.
   logic [12:0]          w_eff, h_eff, wm1, hm1;
   logic                 w_gt1, h_gt1, wh_gt2;
   logic [13:0]          wh_sum;
   logic signed [15:0]   dx_s, dy_s, xd_s;
   logic [NW-1:0]        dx_abs, dy_abs, xd_num;
   logic [NW-1:0]        num_a, num_b;
   logic [DW-1:0]        den_a, den_b;

   always_comb begin
      w_eff  = (width_ff  > DIM_CAP_V) ? DIM_CAP_V : width_ff;
      h_eff  = (height_ff > DIM_CAP_V) ? DIM_CAP_V : height_ff;
      wm1    = w_eff - 13'd1;
      hm1    = h_eff - 13'd1;
      w_gt1  = w_eff > 13'd1;
      h_gt1  = h_eff > 13'd1;
      wh_sum = {1'b0, w_eff} + {1'b0, h_eff};
      wh_gt2 = wh_sum > 14'd2;

      dx_s   = $signed({3'b000, x_ff, 1'b0}) - $signed({3'b000, wm1});
      dy_s   = $signed({3'b000, y_ff, 1'b0}) - $signed({3'b000, hm1});
      dx_abs = (dx_s < 0) ? NW'(-dx_s) : NW'(dx_s);
      dy_abs = (dy_s < 0) ? NW'(-dy_s) : NW'(dy_s);

      // cross diagonal: (w-1-x)+y, a negative sum counts as zero
      xd_s   = $signed({3'b000, w_eff}) - 16'sd1 - $signed({4'b0000, x_ff})
               + $signed({4'b0000, y_ff});
      xd_num = (xd_s < 0) ? '0 : NW'(xd_s);

      num_a = '0;
      den_a = DW'(1);
      num_b = '0;
      den_b = DW'(1);
      unique case (kind_ff)
         tcgp_pkg::KIND_HORIZ: begin
            if (w_gt1) begin
               num_a = NW'(x_ff);
               den_a = DW'(wm1);
            end
         end
         tcgp_pkg::KIND_VERT: begin
            if (h_gt1) begin
               num_b = NW'(y_ff);
               den_b = DW'(hm1);
            end
         end
         tcgp_pkg::KIND_DIAG: begin
            if (wh_gt2) begin
               num_a = NW'(x_ff) + NW'(y_ff);
               den_a = wh_sum - 14'd2;
            end
         end
         tcgp_pkg::KIND_XDIAG: begin
            if (wh_gt2) begin
               num_a = xd_num;
               den_a = wh_sum - 14'd2;
            end
         end
         tcgp_pkg::KIND_PIPE, tcgp_pkg::KIND_ELLIPTIC,
         tcgp_pkg::KIND_RECT, tcgp_pkg::KIND_PYRAMID: begin
            // axis distances; a dimension of 0 or 1 gives distance 0
            if (w_gt1) begin
               num_a = dx_abs;
               den_a = DW'(wm1);
            end
            if (h_gt1) begin
               num_b = dy_abs;
               den_b = DW'(hm1);
            end
         end
         default: ;
      endcase
   end

   // ---------------- stages 1..17: dividers ----------------
   logic [TW-1:0] qa, qb;

   tcgp_div u_div_a (
      .clock   (clock),
      .advance (advance),
      .num_in  (num_a),
      .den_in  (den_a),
      .quot    (qa)
   );

   tcgp_div u_div_b (
      .clock   (clock),
      .advance (advance),
      .num_in  (num_b),
      .den_in  (den_b),
      .quot    (qb)
   );

   // ---------------- stage 18: products ----------------
   logic [TW-1:0]   qa_ff, qb_ff;
   logic [SW-1:0]   sqa_ff, sqb_ff;
   logic [2*TW-1:0] pyr_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         qa_ff  <= qa;
         qb_ff  <= qb;
         sqa_ff <= qa * qa;
         sqb_ff <= qb * qb;
         pyr_ff <= (tcgp_pkg::ONE_FX - qa) * (tcgp_pkg::ONE_FX - qb);
      end
   end

   // ---------------- stage 19: position for all but elliptic ----------------
   logic [TW-1:0] t_sel;
   logic [TW-1:0] tq_ff;
   logic [SW-1:0] rad_ff;

   always_comb begin
      unique case (kind_ff)
         tcgp_pkg::KIND_HORIZ, tcgp_pkg::KIND_DIAG,
         tcgp_pkg::KIND_XDIAG:   t_sel = qa_ff;
         tcgp_pkg::KIND_VERT:    t_sel = qb_ff;
         tcgp_pkg::KIND_PIPE:    t_sel = (qa_ff < qb_ff) ? qa_ff : qb_ff;
         tcgp_pkg::KIND_RECT:    t_sel = (qa_ff > qb_ff) ? qa_ff : qb_ff;
         tcgp_pkg::KIND_PYRAMID: t_sel = tcgp_pkg::ONE_FX - pyr_ff[TW+15:16];
         default:                t_sel = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tq_ff  <= t_sel;
         rad_ff <= sqa_ff + sqb_ff;
      end
   end

   // ---------------- stages 20..36: square root ----------------
   logic [TW-1:0] root;
   logic [TW-1:0] tdly_ff [SQ_STEPS];

   tcgp_sqrt u_sqrt (
      .clock   (clock),
      .advance (advance),
      .rad_in  (rad_ff),
      .root    (root)
   );

   // hold the other kinds' position alongside the root pipeline
   always_ff @(posedge clock) begin
      if (advance) begin
         tdly_ff[0] <= tq_ff;
         for (int i = 1; i < SQ_STEPS; i++) begin
            tdly_ff[i] <= tdly_ff[i-1];
         end
      end
   end

   // ---------------- stage 37: final position ----------------
   logic [TW-1:0] t_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         if (kind_ff == tcgp_pkg::KIND_ELLIPTIC) begin
            t_ff <= (root > tcgp_pkg::ONE_FX) ? tcgp_pkg::ONE_FX : root;
         end else begin
            t_ff <= tdly_ff[SQ_STEPS-1];
         end
      end
   end

   // ---------------- stage 38: blend products ----------------
   // (end - start) * t per channel; t = 0 and t = 1.0 land exactly on the ends
   logic signed [25:0] prod_ff [4];
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int ch = 0; ch < 4; ch++) begin
            prod_ff[ch] <= 26'((($signed({1'b0, end_ff[8*ch +: 8]})
                                 - $signed({1'b0, start_ff[8*ch +: 8]}))
                                * $signed({1'b0, t_ff})));
         end
      end
   end

   // ---------------- stage 39: round half up ----------------
   logic [7:0]         chan_ff [4];
   logic signed [25:0] mix_v   [4];
   always_comb begin
      for (int ch = 0; ch < 4; ch++) begin
         mix_v[ch] = $signed({2'b00, start_ff[8*ch +: 8], 16'h0000}) + prod_ff[ch]
                     + 26'sd32768;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int ch = 0; ch < 4; ch++) begin
            chan_ff[ch] <= mix_v[ch][23:16];
         end
      end
   end

   // ---------------- stage 40: premultiply products ----------------
   // opaque alpha multiplies by 255 and divides back exactly, so no bypass
   logic [15:0] pm_ff [3];
   logic [7:0]  alpha_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         alpha_ff <= chan_ff[3];
         for (int ch = 0; ch < 3; ch++) begin
            pm_ff[ch] <= chan_ff[ch] * chan_ff[3];
         end
      end
   end

   // ---------------- stage 41: divide by 255, interlace, output ----------------
   logic [16:0] d255  [3];
   logic [9:0]  dark  [3];
   logic [7:0]  fin   [3];
   logic        dim_row;
   logic [31:0] argb_ff;

   always_comb begin
      dim_row = ilace_ff && odd_ff[LAT-2];
      for (int ch = 0; ch < 3; ch++) begin
         // floor(p/255) = (p + (p>>8) + 1) >> 8 for p up to 255*255
         d255[ch] = {1'b0, pm_ff[ch]} + {9'd0, pm_ff[ch][15:8]} + 17'd1;
         dark[ch] = {2'b00, d255[ch][15:8]} + {1'b0, d255[ch][15:8], 1'b0} + 10'd2;
         fin[ch]  = dim_row ? dark[ch][9:2] : d255[ch][15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         argb_ff <= {alpha_ff, fin[2], fin[1], fin[0]};
      end
   end

   assign rsp_bus.pixel_argb = argb_ff;

endmodule
`default_nettype wire

FILE: sv/tcgp_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcgp_div
// Pipelined fraction divider: num*65536/den truncated, saturated to 1.0.
// One quotient bit per step stage after the input stage, 17 register stages.
// ----------------------------------------------------------------------------
module tcgp_div (
   input  wire logic                        clock,
   input  wire logic                        advance,
   input  wire logic [tcgp_pkg::NUM_W-1:0]  num_in,
   input  wire logic [tcgp_pkg::DEN_W-1:0]  den_in,
   output logic      [tcgp_pkg::T_W-1:0]    quot
);
   localparam int DW    = tcgp_pkg::DEN_W;
   localparam int STEPS = tcgp_pkg::T_W - 1;

   logic [DW-1:0] rem_ff [STEPS+1];
   logic [DW-1:0] den_ff [STEPS+1];
   logic [STEPS-1:0] q_ff [STEPS+1];
   logic          sat_ff [STEPS+1];

   // num >= den saturates at 1.0, otherwise num fits the remainder
   logic          sat_in;
   assign sat_in = {1'b0, num_in} >= {2'b00, den_in};

   always_ff @(posedge clock) begin
      if (advance) begin
         sat_ff[0] <= sat_in;
         rem_ff[0] <= sat_in ? '0 : num_in[DW-1:0];
         den_ff[0] <= den_in;
         q_ff[0]   <= '0;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic [DW:0]   rem2;
      logic          ge;
      logic [DW-1:0] rem_in;
      always_comb begin
         rem2   = {rem_ff[i], 1'b0};
         ge     = rem2 >= {1'b0, den_ff[i]};
         rem_in = ge ? DW'(rem2 - {1'b0, den_ff[i]}) : rem2[DW-1:0];
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i+1] <= rem_in;
            den_ff[i+1] <= den_ff[i];
            q_ff[i+1]   <= {q_ff[i][STEPS-2:0], ge};
            sat_ff[i+1] <= sat_ff[i];
         end
      end
   end

   assign quot = sat_ff[STEPS] ? tcgp_pkg::ONE_FX : {1'b0, q_ff[STEPS]};

endmodule
`default_nettype wire

FILE: sv/tcgp_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcgp_sqrt
// Pipelined integer square root, two radicand bits per stage, 17 stages.
// ----------------------------------------------------------------------------
module tcgp_sqrt (
   input  wire logic                       clock,
   input  wire logic                       advance,
   input  wire logic [tcgp_pkg::SQ_W-1:0]  rad_in,
   output logic      [tcgp_pkg::T_W-1:0]   root
);
   localparam int SW    = tcgp_pkg::SQ_W;
   localparam int RW    = tcgp_pkg::T_W;
   localparam int STEPS = SW / 2;
   localparam int MW    = RW + 3;

   logic [SW-1:0] rad_ff  [STEPS];
   logic [MW-1:0] rem_ff  [STEPS];
   logic [RW-1:0] root_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [SW-1:0] rad_cur;
      logic [MW-1:0] rem_cur;
      logic [RW-1:0] root_cur;
      logic [MW-1:0] rem_w;
      logic [RW+1:0] trial;
      logic          ge;
      always_comb begin
         if (k == 0) begin
            rad_cur  = rad_in;
            rem_cur  = '0;
            root_cur = '0;
         end else begin
            rad_cur  = rad_ff[(k == 0) ? 0 : k-1];
            rem_cur  = rem_ff[(k == 0) ? 0 : k-1];
            root_cur = root_ff[(k == 0) ? 0 : k-1];
         end
         rem_w = {rem_cur[MW-3:0], rad_cur[SW-1:SW-2]};
         trial = {root_cur, 2'b01};
         ge    = rem_w >= {1'b0, trial};
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rad_ff[k]  <= {rad_cur[SW-3:0], 2'b00};
            rem_ff[k]  <= ge ? MW'(rem_w - {1'b0, trial}) : rem_w;
            root_ff[k] <= {root_cur[RW-2:0], ge};
         end
      end
   end

   assign root = root_ff[STEPS-1];

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Gradient pixel checker: feeds pixel coordinates under several rectangle,
// color, kind and interlace settings, predicts ARGB beats in fixed point or
// uses a known value, and compares every result beat in order to the expectation.
// ----------------------------------------------------------------------------
module tb;

   localparam int LATENCY = 42;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   tcgp_req_if req_bus ();
   tcgp_rsp_if rsp_bus ();

   two_color_gradient_pixel dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor copy of the register file
   logic [12:0]        cfg_width, cfg_height;
   logic [31:0]        cfg_start, cfg_end;
   tcgp_pkg::kind_type cfg_kind;
   logic               cfg_interlace;

   logic [31:0] pending_argb[$];
   int          fail_count = 0;
   bit          rsp_noidle = 0;
   int          rsp_holdoff = 0;

   // directed rows: coordinates, expected color when known by inspection
   typedef struct {
      logic [11:0] col;
      logic [11:0] row;
      bit          known;
      logic [31:0] argb;
   } pixel_row_type;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // truncated num*65536/den, saturated to 1.0
   function automatic longint unsigned scale_ratio(longint num, longint den);
      longint unsigned q;
      if (num <= 0 || den <= 0) return 0;
      q = (longint'(num) * 65536) / den;
      return q > 65536 ? 65536 : q;
   endfunction

   function automatic longint unsigned axis_distance(longint p, longint n);
      longint d;
      if (n <= 1) return 0;
      d = 2 * p - (n - 1);
      if (d < 0) d = -d;
      return scale_ratio(d, n - 1);
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned gradient_pos(longint x, longint y);
      longint w, h;
      longint unsigned dx, dy, r;
      w = cfg_width > tcgp_pkg::MAX_DIM_DEFAULT ? tcgp_pkg::MAX_DIM_DEFAULT : cfg_width;
      h = cfg_height > tcgp_pkg::MAX_DIM_DEFAULT ? tcgp_pkg::MAX_DIM_DEFAULT : cfg_height;
      dx = axis_distance(x, w);
      dy = axis_distance(y, h);
      case (cfg_kind)
         tcgp_pkg::KIND_HORIZ: return (w > 1) ? scale_ratio(x, w - 1) : 0;
         tcgp_pkg::KIND_VERT:  return (h > 1) ? scale_ratio(y, h - 1) : 0;
         tcgp_pkg::KIND_DIAG:  return (w + h > 2) ? scale_ratio(x + y, w + h - 2) : 0;
         tcgp_pkg::KIND_XDIAG:
            return (w + h > 2) ? scale_ratio((w - 1 - x) + y, w + h - 2) : 0;
         tcgp_pkg::KIND_PIPE:  return dx < dy ? dx : dy;
         tcgp_pkg::KIND_ELLIPTIC: begin
            r = floor_sqrt(dx * dx + dy * dy);
            return r > 65536 ? 65536 : r;
         end
         tcgp_pkg::KIND_RECT:  return dx > dy ? dx : dy;
         default: begin
            dx = (w > 1) ? 65536 - dx : 65536;
            dy = (h > 1) ? 65536 - dy : 65536;
            return 65536 - ((dx * dy) >> 16);
         end
      endcase
   endfunction

   function automatic logic [31:0] gradient_argb(logic [11:0] col, logic [11:0] row);
      longint unsigned t;
      longint v;
      logic [31:0] c;
      int unsigned a, ch[3];
      t = gradient_pos(col, row);
      if (t == 0) c = cfg_start;
      else if (t >= 65536) c = cfg_end;
      else begin
         for (int s = 0; s < 4; s++) begin
            v = longint'(cfg_start[8*s +: 8]) * 65536
                + (longint'(cfg_end[8*s +: 8]) - longint'(cfg_start[8*s +: 8])) * longint'(t)
                + 32768;
            if (v < 0) v = 0;
            v = v >>> 16;
            c[8*s +: 8] = v > 255 ? 8'd255 : v[7:0];
         end
      end
      a = c[31:24];
      for (int i = 0; i < 3; i++) begin
         ch[i] = c[8*i +: 8];
         if (a < 255) ch[i] = ch[i] * a / 255;
         if (cfg_interlace && row[0]) ch[i] = (3 * ch[i] + 2) >> 2;
      end
      return {c[31:24], ch[2][7:0], ch[1][7:0], ch[0][7:0]};
   endfunction

   // write one register while the block is idle
   task automatic write_reg(tcgp_pkg::reg_index_type idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         tcgp_pkg::REG_WIDTH:     cfg_width = val[12:0];
         tcgp_pkg::REG_HEIGHT:    cfg_height = val[12:0];
         tcgp_pkg::REG_START:     cfg_start = val;
         tcgp_pkg::REG_END:       cfg_end = val;
         tcgp_pkg::REG_KIND:      cfg_kind = tcgp_pkg::kind_type'(val[2:0]);
         tcgp_pkg::REG_INTERLACE: cfg_interlace = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic setup(int w, int h, logic [31:0] s, logic [31:0] e,
                        tcgp_pkg::kind_type k, bit il);
      write_reg(tcgp_pkg::REG_WIDTH, 32'(w));
      write_reg(tcgp_pkg::REG_HEIGHT, 32'(h));
      write_reg(tcgp_pkg::REG_START, s);
      write_reg(tcgp_pkg::REG_END, e);
      write_reg(tcgp_pkg::REG_KIND, 32'(k));
      write_reg(tcgp_pkg::REG_INTERLACE, 32'(il));
   endtask

   // wait until all results drained, plus a margin for the pipe
   task automatic drain();
      int guard;
      guard = 0;
      while (pending_argb.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // offer one beat at the falling edge, hold until accepted
   task automatic send_pixel(logic [11:0] col, logic [11:0] row, bit idle_ok,
                             bit known, logic [31:0] argb);
      if (idle_ok) begin
         while ($urandom_range(99) < 36) begin
            req_bus.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel_col <= col;
      req_bus.pixel_row <= row;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_argb.push_back(known ? argb : gradient_argb(col, row));
      @(negedge clock);
   endtask

   task automatic stop_sending();
      req_bus.valid <= 1'b0;
   endtask

   // response side: random ready, with a long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_holdoff > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_holdoff <= rsp_holdoff - 1;
      end else begin
         rsp_bus.ready <= rsp_noidle ? 1'b1 : ($urandom_range(99) >= 36);
      end
   end

   // compare each accepted result beat against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_argb.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %h", $time,
                     rsp_bus.pixel_argb);
            fail_count++;
         end else begin
            if (rsp_bus.pixel_argb !== pending_argb[0]) begin
               $display("%0t: pixel_argb expected %h actual %h", $time,
                        pending_argb[0], rsp_bus.pixel_argb);
               fail_count++;
            end
            void'(pending_argb.pop_front());
         end
      end
   end

   pixel_row_type directed[$];

   initial begin
      logic [11:0] c, r;
      int w, h, sel;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = tcgp_pkg::REG_WIDTH;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.pixel_col = '0;
      req_bus.pixel_row = '0;
      cfg_width = 1; cfg_height = 1;
      cfg_start = 32'hFF000000; cfg_end = 32'hFF000000;
      cfg_kind = tcgp_pkg::KIND_HORIZ; cfg_interlace = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // after reset: 1x1 opaque black regardless of coordinate
      directed = '{
         '{12'd0, 12'd0, 1, 32'hFF000000},
         '{12'hFFF, 12'hFFF, 1, 32'hFF000000},
         '{12'hAAA, 12'h555, 1, 32'hFF000000}
      };
      foreach (directed[i])
         send_pixel(directed[i].col, directed[i].row, 0, directed[i].known, directed[i].argb);
      stop_sending();
      drain();

      // horizontal edges give the end colors exactly; translucent start premultiplies
      setup(4096, 4096, 32'h80FF4020, 32'hFF0080FF, tcgp_pkg::KIND_HORIZ, 0);
      directed = '{
         '{12'd0, 12'd0, 1, 32'h80802010},
         '{12'd4095, 12'd0, 1, 32'hFF0080FF},
         '{12'd2048, 12'd7, 0, 0},
         '{12'd1, 12'hFFF, 0, 0}
      };
      foreach (directed[i])
         send_pixel(directed[i].col, directed[i].row, 0, directed[i].known, directed[i].argb);
      stop_sending();
      drain();

      // each kind once, with interlace and a beyond-max size, outside coords
      for (int k = 0; k < 8; k++) begin
         setup(k == 7 ? 8191 : 13, 7, 32'h00FFFFFF, 32'hFE123456,
               tcgp_pkg::kind_type'(k), 1);
         send_pixel(12'd6, 12'd3, 0, 0, 0);
         send_pixel(12'd0, 12'd1, 0, 0, 0);
         send_pixel(12'hFFF, 12'hFFF, 0, 0, 0);
         stop_sending();
         drain();
      end
      // degenerate sizes: pyramid with width 1, diagonal with width 0 and height 1
      setup(1, 5, 32'hFFFFFFFF, 32'h7F102030, tcgp_pkg::KIND_PYRAMID, 0);
      send_pixel(12'd0, 12'd2, 0, 0, 0);
      stop_sending(); drain();
      setup(0, 1, 32'hFFFFFFFF, 32'h7F102030, tcgp_pkg::KIND_DIAG, 0);
      send_pixel(12'd3, 12'd0, 0, 1, 32'hFFFFFFFF);
      stop_sending(); drain();

      // random phases: mostly in-range coords, some outside
      for (int ph = 0; ph < 14; ph++) begin
         sel = $urandom_range(9);
         w = (sel < 6) ? $urandom_range(1, 64) : (sel < 8) ? $urandom_range(1, 8191) : 4096;
         h = (sel < 5) ? $urandom_range(1, 64) : $urandom_range(1, 8191);
         setup(w, h, $urandom, $urandom, tcgp_pkg::kind_type'($urandom_range(7)),
               1'($urandom_range(1)));
         rsp_noidle = (ph == 3);
         if (ph == 5) rsp_holdoff = 300;
         for (int n = 0; n < 50; n++) begin
            if ($urandom_range(9) == 0) begin
               c = 12'($urandom); r = 12'($urandom);
            end else begin
               c = 12'($urandom_range(w > 4096 ? 4095 : w - 1));
               r = 12'($urandom_range(h > 4096 ? 4095 : h - 1));
            end
            send_pixel(c, r, ph != 3 && ph != 5, 0, 0);
         end
         stop_sending();
         // sender pauses until every result is back
         drain();
      end
      rsp_noidle = 0;

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
